FILE: hw/rtl/chacha_pkg.sv
// shared types, constants and the state-word initialiser for the chacha20 stream xor block
package chacha_pkg;

  localparam int NUM_WORDS   = 16;
  localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
  localparam int DBL_ROUNDS  = 10;
  // two half quarter-rounds per quarter-round, eight quarter-rounds per double round
  localparam int RND_STEPS   = DBL_ROUNDS * 16;
  localparam int RND_CNT_W   = $clog2(RND_STEPS);
  localparam int NUM_REGS    = 7;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

  typedef enum logic [2:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_NONCE_L = 3'd4,
    REG_NONCE_H = 3'd5,
    REG_CTR     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic             restart;
    logic [31:0]      ctr_load;
  } chacha_cfg_t;

  function automatic logic [31:0] init_word(input chacha_cfg_t c, input logic [31:0] ctr,
                                            input logic [WORD_IDX_W-1:0] idx);
    logic [31:0] w;
    case (idx) inside
      [4'd0:4'd3]:  w = SIGMA[idx[1:0]];
      [4'd4:4'd11]: w = c.key[3'(idx - 4'd4)];
      4'd12:        w = ctr;
      default:      w = c.nonce[2'(idx - 4'd13)];
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/chacha_hqr.sv
// half quarter-round unit: two add, xor and rotate steps on one column of the state
module chacha_hqr import chacha_pkg::*; (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic        second_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a_sum;
  logic [31:0] d_x;
  logic [31:0] d_rot;
  logic [31:0] c_sum;
  logic [31:0] b_x;
  logic [31:0] b_rot;

  always_comb begin
    a_sum = a_i + b_i;
    d_x   = d_i ^ a_sum;
    d_rot = second_i ? {d_x[23:0], d_x[31:24]} : {d_x[15:0], d_x[31:16]};
    c_sum = c_i + d_rot;
    b_x   = b_i ^ c_sum;
    b_rot = second_i ? {b_x[24:0], b_x[31:25]} : {b_x[19:0], b_x[31:20]};
  end

  assign a_o = a_sum;
  assign b_o = b_rot;
  assign c_o = c_sum;
  assign d_o = d_rot;

endmodule

FILE: hw/rtl/chacha_cfg.sv
// apb register file for key, nonce and initial block counter
module chacha_cfg import chacha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output chacha_cfg_t       cfg_o
);

  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_lo_r;
  logic [31:0]      nonce_hi_r;
  logic [31:0]      ctr_init_r;
  logic             wr_en;
  logic             wr_hit;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    wr_hit = 1'b1;
    prdata = '0;
    unique case (idx)
      REG_KEY0:    prdata = key_r[0];
      REG_KEY1:    prdata = key_r[1];
      REG_KEY2:    prdata = key_r[2];
      REG_KEY3:    prdata = key_r[3];
      REG_NONCE_L: prdata = nonce_lo_r;
      REG_NONCE_H: prdata = {32'd0, nonce_hi_r};
      REG_CTR:     prdata = {32'd0, ctr_init_r};
      default:     wr_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      ctr_init_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY0:    key_r[0]   <= pwdata;
        REG_KEY1:    key_r[1]   <= pwdata;
        REG_KEY2:    key_r[2]   <= pwdata;
        REG_KEY3:    key_r[3]   <= pwdata;
        REG_NONCE_L: nonce_lo_r <= pwdata;
        REG_NONCE_H: nonce_hi_r <= pwdata[31:0];
        REG_CTR:     ctr_init_r <= pwdata[31:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cfg_o.key[2*k]   = key_r[k][31:0];
      cfg_o.key[2*k+1] = key_r[k][63:32];
    end
    cfg_o.nonce[0] = nonce_lo_r[31:0];
    cfg_o.nonce[1] = nonce_lo_r[63:32];
    cfg_o.nonce[2] = nonce_hi_r;
    cfg_o.restart  = wr_en && wr_hit;
    cfg_o.ctr_load = (wr_en && idx == REG_CTR) ? pwdata[31:0] : ctr_init_r;
  end

endmodule

FILE: hw/rtl/chacha_core.sv
// sequencer, state word line, block counter and byte output stage
module chacha_core import chacha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chacha_cfg_t cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_result_byte
);

  localparam logic [RND_CNT_W-1:0]  RND_LAST = RND_CNT_W'(RND_STEPS - 1);
  localparam logic [WORD_IDX_W-1:0] FIN_LAST = WORD_IDX_W'(NUM_WORDS - 1);

  state_t                  state_r, state_nxt;
  logic [31:0]             st_r [NUM_WORDS];
  logic [31:0]             st_nxt [NUM_WORDS];
  logic [31:0]             grid [NUM_WORDS];
  logic [RND_CNT_W-1:0]    rnd_cnt_r, rnd_cnt_nxt;
  logic [WORD_IDX_W-1:0]   fin_cnt_r, fin_cnt_nxt;
  logic [5:0]              pos_r, pos_nxt;
  logic                    blk_ready_r, blk_ready_nxt;
  logic [31:0]             ctr_r, ctr_nxt;
  logic [7:0]              data_r;
  logic                    eom_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;

  logic        out_free;
  logic        in_fire;
  logic        emit_go;
  logic        issue;
  logic        blk_end;
  logic [7:0]  iss_data;
  logic        iss_eom;
  logic [7:0]  ks_byte;
  logic        second;
  logic [1:0]  qr_sel;
  logic        diag;
  logic [31:0] qa, qb, qc, qd;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;
  assign issue    = (in_fire && blk_ready_r) || emit_go;
  assign iss_data = (state_r == ST_IDLE) ? in_data_byte : data_r;
  assign iss_eom  = (state_r == ST_IDLE) ? in_end_of_message : eom_r;
  assign ks_byte  = st_r[0][{pos_r[1:0], 3'b000} +: 8];
  assign blk_end  = issue && (pos_r == 6'd63 || iss_eom);

  assign second = rnd_cnt_r[0];
  assign qr_sel = rnd_cnt_r[2:1];
  assign diag   = rnd_cnt_r[3];

  chacha_hqr u_hqr (
    .a_i      (st_r[0]),
    .b_i      (st_r[4]),
    .c_i      (st_r[8]),
    .d_i      (st_r[12]),
    .second_i (second),
    .a_o      (qa),
    .b_o      (qb),
    .c_o      (qc),
    .d_o      (qd)
  );

  always_comb begin
    logic [1:0] amt;
    logic [1:0] rr;
    logic [1:0] cc;
    for (int i = 0; i < NUM_WORDS; i++) begin
      grid[i]   = st_r[i];
      st_nxt[i] = st_r[i];
    end
    grid[0]  = qa;
    grid[4]  = qb;
    grid[8]  = qc;
    grid[12] = qd;
    amt = 2'd1;
    rr  = 2'd0;
    cc  = 2'd0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !blk_ready_r) begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            st_nxt[i] = init_word(cfg, ctr_r, WORD_IDX_W'(i));
          end
        end else if (issue && pos_r[1:0] == 2'd3) begin
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            st_nxt[i] = st_r[i+1];
          end
          st_nxt[NUM_WORDS-1] = st_r[0];
        end
      end
      ST_ROUND: begin
        if (!second) begin
          for (int i = 0; i < NUM_WORDS; i++) begin
            st_nxt[i] = grid[i];
          end
        end else begin
          // rotate rows so the next column or diagonal sits in column 0
          for (int r = 0; r < 4; r++) begin
            rr = 2'(r);
            if (qr_sel != 2'd3) begin
              amt = 2'd1;
            end else if (!diag) begin
              amt = rr + 2'd1;
            end else begin
              amt = 2'd1 - rr;
            end
            for (int c = 0; c < 4; c++) begin
              cc = 2'(c) + amt;
              st_nxt[4*r+c] = grid[{rr, cc}];
            end
          end
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < NUM_WORDS - 1; i++) begin
          st_nxt[i] = st_r[i+1];
        end
        st_nxt[NUM_WORDS-1] = st_r[0] + init_word(cfg, ctr_r, fin_cnt_r);
      end
      ST_EMIT: begin
        if (emit_go && pos_r[1:0] == 2'd3) begin
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            st_nxt[i] = st_r[i+1];
          end
          st_nxt[NUM_WORDS-1] = st_r[0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    rnd_cnt_nxt = rnd_cnt_r;
    fin_cnt_nxt = fin_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !blk_ready_r) begin
          state_nxt   = ST_ROUND;
          rnd_cnt_nxt = '0;
          fin_cnt_nxt = '0;
        end
      end
      ST_ROUND: begin
        rnd_cnt_nxt = rnd_cnt_r + 1'b1;
        if (rnd_cnt_r == RND_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        fin_cnt_nxt = fin_cnt_r + 1'b1;
        if (fin_cnt_r == FIN_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctr_nxt       = ctr_r;
    pos_nxt       = pos_r;
    blk_ready_nxt = blk_ready_r;
    if (cfg.restart) begin
      ctr_nxt       = cfg.ctr_load;
      pos_nxt       = '0;
      blk_ready_nxt = 1'b0;
    end else begin
      if (state_r == ST_FINAL && fin_cnt_r == FIN_LAST) begin
        blk_ready_nxt = 1'b1;
        pos_nxt       = '0;
      end
      if (blk_end) begin
        ctr_nxt       = ctr_r + 32'd1;
        blk_ready_nxt = 1'b0;
        pos_nxt       = '0;
      end else if (issue) begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    if (issue) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = iss_data ^ ks_byte;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_cnt_r   <= '0;
      fin_cnt_r   <= '0;
      pos_r       <= '0;
      blk_ready_r <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_cnt_r   <= rnd_cnt_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      pos_r       <= pos_nxt;
      blk_ready_r <= blk_ready_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      st_r[i] <= st_nxt[i];
    end
    out_byte_r <= out_byte_nxt;
    if (in_fire) begin
      data_r <= in_data_byte;
      eom_r  <= in_end_of_message;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_byte_r;

  a_cold_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !blk_ready_r) |=> (state_r == ST_ROUND && rnd_cnt_r == '0))
    else $error("block computation did not start on a transfer without keystream");

  a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_cnt_r == RND_LAST) |=> (state_r == ST_FINAL))
    else $error("round sequence did not hand over to the final addition");

  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL && fin_cnt_r == FIN_LAST) |=> (state_r == ST_EMIT))
    else $error("final addition did not hand over to the byte output");

  a_issue_out: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> out_valid_r)
    else $error("issued byte not held in the output register");

endmodule

FILE: hw/rtl/chacha20_stream_xor_top.sv
// top level of the chacha20 stream xor block: apb registers and keystream core
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+-----------------------------------
//   in       | in_valid / in_ready              | in_data_byte, in_end_of_message
//   out      | out_valid / out_ready            | out_result_byte
//   cfg      | psel, penable, pwrite / pready   | paddr, pwdata, prdata
//
// a byte that finds a keystream block held leaves on the next cycle, one byte per cycle
// while out_ready is high; a byte that needs a new block waits for the state load,
// 160 half quarter-rounds through the one shared unit, the 16 final word additions
// and the emit state; in_ready is low meanwhile and while a full output is not taken
// reset clears the registers, the counter and the byte position; no clearing pass
module chacha20_stream_xor_top import chacha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_result_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  chacha_cfg_t cfg;

  chacha_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  chacha_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_byte   (out_result_byte)
  );

endmodule

FILE: dv/chacha20_stream_xor_checker.sv
// checker for the chacha20 stream xor block: keystream prediction and result comparison
`timescale 1ns / 100ps

module chacha20_stream_xor_checker import chacha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_result_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending_results
);

  logic [63:0] key_regs [NUM_REGS];
  logic [31:0] block_ctr;
  logic [31:0] ks_words [NUM_WORDS];
  logic [5:0]  ks_pos;
  logic        ks_valid;
  logic [7:0]  cipher_bytes_due [$];

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    logic [31:0] init_w [NUM_WORDS];
    logic [31:0] work [NUM_WORDS];
    logic [31:0] a, b, c, d;
    int          la, lb, lc, ld;
    logic [2:0]  ridx;
    logic [7:0]  ks, due;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) key_regs[i] = '0;
      block_ctr = '0;
      ks_pos    = '0;
      ks_valid  = 1'b0;
      cipher_bytes_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_bytes_due.size() == 0) begin
          report_mismatch($sformatf("result byte 0x%02h with nothing expected",
                                    out_result_byte));
        end else begin
          due = cipher_bytes_due.pop_front();
          if (out_result_byte !== due)
            report_mismatch($sformatf("result_byte 0x%02h, expected 0x%02h",
                                      out_result_byte, due));
        end
      end
      if (psel && penable && pwrite && pready) begin
        ridx = paddr[5:3];
        if (ridx < NUM_REGS) begin
          if (ridx == REG_NONCE_H || ridx == REG_CTR)
            key_regs[ridx] = {32'h0, pwdata[31:0]};
          else
            key_regs[ridx] = pwdata;
          block_ctr = key_regs[REG_CTR][31:0];
          ks_pos    = '0;
          ks_valid  = 1'b0;
        end
      end
      if (in_valid && in_ready) begin
        if (!ks_valid) begin
          for (int i = 0; i < 4; i++) init_w[i] = SIGMA[i];
          for (int i = 0; i < 8; i++) init_w[4 + i] = key_regs[i / 2][32 * (i % 2) +: 32];
          init_w[12] = block_ctr;
          init_w[13] = key_regs[REG_NONCE_L][31:0];
          init_w[14] = key_regs[REG_NONCE_L][63:32];
          init_w[15] = key_regs[REG_NONCE_H][31:0];
          for (int i = 0; i < NUM_WORDS; i++) work[i] = init_w[i];
          for (int r = 0; r < DBL_ROUNDS; r++) begin
            for (int q = 0; q < 8; q++) begin
              // column rounds, then diagonal rounds
              if (q < 4) begin
                la = q;
                lb = 4 + q;
                lc = 8 + q;
                ld = 12 + q;
              end else begin
                la = q - 4;
                lb = 4 + (q - 3) % 4;
                lc = 8 + (q - 2) % 4;
                ld = 12 + (q - 1) % 4;
              end
              a = work[la];
              b = work[lb];
              c = work[lc];
              d = work[ld];
              a = a + b; d = rotl32(d ^ a, 16);
              c = c + d; b = rotl32(b ^ c, 12);
              a = a + b; d = rotl32(d ^ a, 8);
              c = c + d; b = rotl32(b ^ c, 7);
              work[la] = a;
              work[lb] = b;
              work[lc] = c;
              work[ld] = d;
            end
          end
          for (int i = 0; i < NUM_WORDS; i++) ks_words[i] = work[i] + init_w[i];
          ks_valid = 1'b1;
          ks_pos   = '0;
        end
        ks = ks_words[ks_pos[5:2]][8 * ks_pos[1:0] +: 8];
        cipher_bytes_due.push_back(in_data_byte ^ ks);
        if (ks_pos == 6'd63 || in_end_of_message) begin
          block_ctr = block_ctr + 32'd1;
          ks_valid  = 1'b0;
          ks_pos    = '0;
        end else begin
          ks_pos = ks_pos + 6'd1;
        end
      end
    end
    pending_results = cipher_bytes_due.size();
  end

endmodule

FILE: dv/chacha20_stream_xor_top_test.sv
// testbench top for the chacha20 stream xor block: stimulus, register writes and verdict
`timescale 1ns / 100ps

module chacha20_stream_xor_top_test;
  import chacha_pkg::*;

  localparam int RANDOM_ITEMS   = 500;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int TAIL_CYCLES    = 200;
  localparam int UNUSED_REG_IDX = NUM_REGS;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = '0;
  logic              in_end_of_message = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_result_byte;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  chacha20_stream_xor_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_byte   (out_result_byte),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  chacha20_stream_xor_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_byte   (out_result_byte),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .fail_count        (fail_count),
    .pending_results   (pending_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
  end

  task automatic send_byte(input logic [7:0] data, input logic eom);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_message(input int len, input bit with_eom);
    for (int k = 0; k < len; k++)
      send_byte(8'($urandom_range(255)), with_eom && (k == len - 1));
  endtask

  // sender holds off until every transfer in flight has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_items;
    int          base;
    int          len;
    int          kind;
    logic [63:0] v;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset values, end of message inside a block and single-byte message
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b1);

    // all-ones key and nonce, counter at its top so it wraps
    drain_results();
    apb_write(REG_KEY0, '1);
    apb_write(REG_KEY1, '1);
    apb_write(REG_KEY2, '1);
    apb_write(REG_KEY3, '1);
    apb_write(REG_NONCE_L, '1);
    apb_write(REG_NONCE_H, 64'hDEAD_BEEF_FFFF_FFFF);
    apb_write(REG_CTR, 64'h1234_5678_FFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);

    // write to an unused address must leave the block position alone
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    drain_results();
    apb_write(UNUSED_REG_IDX, '1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h10, 1'b1);

    drain_results();
    apb_write(REG_KEY0, 64'h0706_0504_0302_0100);
    apb_write(REG_KEY1, 64'h0F0E_0D0C_0B0A_0908);
    apb_write(REG_KEY2, 64'h1716_1514_1312_1110);
    apb_write(REG_KEY3, 64'h1F1E_1D1C_1B1A_1918);
    apb_write(REG_NONCE_L, 64'h4A00_0000_0900_0000);
    apb_write(REG_NONCE_H, 64'h0);
    apb_write(REG_CTR, 64'h1);
    send_byte(8'h4C, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h64, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);

    // register write in mid block restarts the stream
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    drain_results();
    apb_write(REG_CTR, 64'h0);
    send_byte(8'h55, 1'b1);

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      drain_results();
      for (int r = 0; r < NUM_REGS; r++) begin
        if (phase == 0 || $urandom_range(1) == 1) begin
          kind = $urandom_range(3);
          v = (kind == 0) ? 64'h0 : (kind == 1) ? '1 : {$urandom, $urandom};
          if (r == REG_CTR && $urandom_range(2) == 0)
            v = 64'(32'hFFFF_FFFF - 32'($urandom_range(2)));
          apb_write(r, v);
        end
      end
      if ($urandom_range(3) == 0) apb_write(UNUSED_REG_IDX, {$urandom, $urandom});
      quiet = (phase == 3);
      if (phase == 0) run_message(64, 1'b1);
      phase_items = 0;
      while (phase_items < 80) begin
        kind = $urandom_range(99);
        len  = (kind < 8) ? $urandom_range(140, 65) : $urandom_range(48, 1);
        // mostly whole messages, some runs with no end marker
        run_message(len, kind < 85);
        phase_items += len;
        if (phase == 2 && phase_items < 40) drain_results();
      end
      phase++;
    end

    drain_results();
    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_hqr.sv
hw/rtl/chacha_cfg.sv
hw/rtl/chacha_core.sv
hw/rtl/chacha20_stream_xor_top.sv
dv/chacha20_stream_xor_checker.sv
dv/chacha20_stream_xor_top_test.sv
